// ===== rtl/aluex_pkg.sv =====
// Shared types and constants for the 8-bit ALU execute stage.
// Used by aluex_alu and alu_execute_stage_8bit_top; no dependencies.
package aluex_pkg;

  localparam int unsigned FLAGS_W = 5;
  localparam int unsigned FLAG_C  = 4;
  localparam int unsigned FLAG_V  = 3;
  localparam int unsigned FLAG_N  = 2;
  localparam int unsigned FLAG_S  = 1;
  localparam int unsigned FLAG_Z  = 0;

  // Shift amount and memory address field come from the low bits of the immediate.
  localparam int unsigned IMM_FIELD_W = 6;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_LDI  = 4'd3,
    OP_BEQZ = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_JR   = 4'd7,
    OP_SAL  = 4'd8,
    OP_SAR  = 4'd9,
    OP_LB   = 4'd10,
    OP_SB   = 4'd11
  } op_e;

  typedef struct packed {
    logic [3:0]         mode;
    logic [5:0]         dest_reg;
    logic signed [7:0]  first_value;
    logic signed [7:0]  second_value;
    logic signed [7:0]  immediate;
    logic [15:0]        instr_pc;
  } instr_t;

  typedef struct packed {
    logic               reg_write;
    logic [5:0]         write_reg;
    logic signed [7:0]  write_value;
    logic [FLAGS_W-1:0] flags;
    logic               branch_taken;
    logic [15:0]        target_pc;
    logic               bad_opcode;
  } result_t;

endpackage

// ===== rtl/alu_execute_stage_8bit_top.sv =====
// Execute stage of an 8-bit pipelined processor: ALU, flags, branches, data memory.
// An accepted request is held in stage one; its result is then registered in the output register.
// Throughput: one request per cycle; a held result stalls the input once both stages
// are full. The memory read is issued at accept, a store writes as it leaves stage one.
// Reset: flags clear; each memory entry has a valid bit cleared at once, so an
// unwritten entry reads as zero and no clearing pass is needed.
module alu_execute_stage_8bit_top #(
  parameter int unsigned REG_COUNT = 64,
  parameter int unsigned MEM_DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [3:0]                    mode_i,
  input  logic [5:0]                    dest_reg_i,
  input  logic signed [7:0]             first_value_i,
  input  logic signed [7:0]             second_value_i,
  input  logic signed [7:0]             immediate_i,
  input  logic [15:0]                   instr_pc_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          reg_write_o,
  output logic [5:0]                    write_reg_o,
  output logic signed [7:0]             write_value_o,
  output logic [aluex_pkg::FLAGS_W-1:0] flags_o,
  output logic                          branch_taken_o,
  output logic [15:0]                   target_pc_o,
  output logic                          bad_opcode_o
);
  import aluex_pkg::*;

  localparam int unsigned AW       = $clog2(MEM_DEPTH);
  localparam int unsigned FIELD_SZ = 2 ** IMM_FIELD_W;

  // immediate field to memory index, folded by the memory depth
  logic [AW-1:0] addr_lut [FIELD_SZ];
  for (genvar g = 0; g < FIELD_SZ; g++) begin : g_addr_lut
    assign addr_lut[g] = AW'(g % MEM_DEPTH);
  end

  instr_t             s1_q;
  logic               s1_valid_q;
  logic               s1_fire;
  logic               in_fire;
  logic [FLAGS_W-1:0] flags_q;
  logic [MEM_DEPTH-1:0] mem_vld_q;
  logic               rd_vld_q;
  logic               fwd_hit_q;
  logic [7:0]         fwd_data_q;
  logic [AW-1:0]      in_addr;
  logic [AW-1:0]      s1_addr;
  logic               ram_we;
  logic [7:0]         ram_rdata;
  logic [7:0]         load_data;
  result_t            alu_res;
  result_t            out_q;
  logic               out_valid_q;

  assign in_addr = addr_lut[immediate_i[IMM_FIELD_W-1:0]];
  assign s1_addr = addr_lut[s1_q.immediate[IMM_FIELD_W-1:0]];

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ram_we     = s1_fire && (s1_q.mode == OP_SB);

  aluex_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_addr),
    .wdata_i(s1_q.first_value),
    .re_i   (in_fire),
    .raddr_i(in_addr),
    .rdata_o(ram_rdata)
  );

  // a store retiring in the same cycle as the read bypasses the RAM
  assign load_data = fwd_hit_q ? fwd_data_q : (rd_vld_q ? ram_rdata : 8'd0);

  aluex_alu #(
    .REG_COUNT(REG_COUNT)
  ) u_alu (
    .instr_i    (s1_q),
    .flags_i    (flags_q),
    .load_data_i(load_data),
    .res_o      (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      mem_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      fwd_hit_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        flags_q     <= alu_res.flags;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        mem_vld_q[s1_addr] <= 1'b1;
      end
      if (in_fire) begin
        rd_vld_q  <= mem_vld_q[in_addr];
        fwd_hit_q <= ram_we && (s1_addr == in_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.mode         <= mode_i;
      s1_q.dest_reg     <= dest_reg_i;
      s1_q.first_value  <= first_value_i;
      s1_q.second_value <= second_value_i;
      s1_q.immediate    <= immediate_i;
      s1_q.instr_pc     <= instr_pc_i;
      fwd_data_q        <= s1_q.first_value;
    end
    if (s1_fire) begin
      out_q <= alu_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reg_write_o    = out_q.reg_write;
  assign write_reg_o    = out_q.write_reg;
  assign write_value_o  = out_q.write_value;
  assign flags_o        = out_q.flags;
  assign branch_taken_o = out_q.branch_taken;
  assign target_pc_o    = out_q.target_pc;
  assign bad_opcode_o   = out_q.bad_opcode;

`ifndef SYNTH
  a_wb_excl_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_write_o |-> !branch_taken_o)
    else $error("write-back and branch in one result");

  a_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !branch_taken_o |-> target_pc_o == 16'd0)
    else $error("target without taken branch");

  a_bad_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && alu_res.bad_opcode |=> flags_q == $past(flags_q))
    else $error("unknown opcode changed flags");

  a_store_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> mem_vld_q[$past(s1_addr)])
    else $error("stored entry not marked valid");
`endif

endmodule

// ===== rtl/aluex_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aluex_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/aluex_alu.sv =====
// ALU, branch and flag logic of the execute stage, purely combinational.
// Depends on aluex_pkg.
module aluex_alu #(
  parameter int unsigned REG_COUNT = 64
) (
  input  aluex_pkg::instr_t                 instr_i,
  input  logic [aluex_pkg::FLAGS_W-1:0]     flags_i,
  input  logic [7:0]                        load_data_i,
  output aluex_pkg::result_t                res_o
);
  import aluex_pkg::*;

  logic [7:0]             a;
  logic [7:0]             b;
  logic [8:0]             sum;
  logic [7:0]             diff;
  logic [15:0]            prod;
  logic [IMM_FIELD_W-1:0] sh;
  logic [2:0]             sar_amt;
  logic                   dest_ok;

  assign a       = instr_i.first_value;
  assign b       = instr_i.second_value;
  assign sum     = {1'b0, a} + {1'b0, b};
  assign diff    = a - b;
  assign prod    = a * b;
  assign sh      = instr_i.immediate[IMM_FIELD_W-1:0];
  assign sar_amt = (sh >= IMM_FIELD_W'(8)) ? 3'd7 : sh[2:0];
  assign dest_ok = {1'b0, instr_i.dest_reg} < 7'(REG_COUNT);

  always_comb begin
    logic [7:0]         res;
    logic               wr;
    logic               set_nz;
    logic [FLAGS_W-1:0] fl;
    logic               taken;
    logic [15:0]        target;
    logic               bad;

    res    = '0;
    wr     = 1'b0;
    set_nz = 1'b0;
    fl     = flags_i;
    taken  = 1'b0;
    target = '0;
    bad    = 1'b0;

    case (instr_i.mode)
      OP_ADD: begin
        res        = sum[7:0];
        wr         = 1'b1;
        set_nz     = 1'b1;
        fl[FLAG_C] = sum[8];
        fl[FLAG_V] = (a[7] == b[7]) && (res[7] != a[7]);
        fl[FLAG_S] = res[7] ^ fl[FLAG_V];
      end
      OP_SUB: begin
        res        = diff;
        wr         = 1'b1;
        set_nz     = 1'b1;
        fl[FLAG_V] = (a[7] != b[7]) && (res[7] != a[7]);
        fl[FLAG_S] = res[7] ^ fl[FLAG_V];
      end
      OP_MUL: begin
        res    = prod[7:0];
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      OP_LDI: begin
        res = instr_i.immediate;
        wr  = 1'b1;
      end
      OP_BEQZ: begin
        if (a == 8'd0) begin
          taken  = 1'b1;
          target = instr_i.instr_pc + 16'd1
                 + {{8{instr_i.immediate[7]}}, instr_i.immediate};
        end
      end
      OP_AND: begin
        res    = a & b;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      OP_OR: begin
        res    = a | b;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      OP_JR: begin
        taken  = 1'b1;
        target = {a, b};
      end
      OP_SAL: begin
        res    = (sh >= IMM_FIELD_W'(8)) ? 8'd0 : (a << sh[2:0]);
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      OP_SAR: begin
        res    = $signed(a) >>> sar_amt;
        wr     = 1'b1;
        set_nz = 1'b1;
      end
      OP_LB: begin
        res = load_data_i;
        wr  = 1'b1;
      end
      OP_SB: begin
        // memory write is issued by the stage control
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (set_nz) begin
      fl[FLAG_N] = res[7];
      fl[FLAG_Z] = (res == 8'd0);
    end

    // drop the write-back for a destination outside the register file
    wr = wr && dest_ok;

    res_o.reg_write    = wr;
    res_o.write_reg    = wr ? instr_i.dest_reg : 6'd0;
    res_o.write_value  = wr ? res : 8'd0;
    res_o.flags        = fl;
    res_o.branch_taken = taken;
    res_o.target_pc    = target;
    res_o.bad_opcode   = bad;
  end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for alu_execute_stage_8bit_top: directed table plus random
// instruction streams, checked against table results or an in-bench execute model with flags and memory.
// Depends on aluex_pkg and the top-level RTL only.
module tb;
  import aluex_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned HOLD_CYCLES  = 48;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MEM_WORDS    = 64;
  localparam logic [3:0]  OP_BAD_LO    = 4'd12;
  localparam logic [3:0]  OP_BAD_HI    = 4'd15;

  typedef struct {
    instr_t  ins;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic [3:0]         mode_i         = '0;
  logic [5:0]         dest_reg_i     = '0;
  logic signed [7:0]  first_value_i  = '0;
  logic signed [7:0]  second_value_i = '0;
  logic signed [7:0]  immediate_i    = '0;
  logic [15:0]        instr_pc_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic               reg_write_o;
  logic [5:0]         write_reg_o;
  logic signed [7:0]  write_value_o;
  logic [FLAGS_W-1:0] flags_o;
  logic               branch_taken_o;
  logic [15:0]        target_pc_o;
  logic               bad_opcode_o;

  // execute model state
  logic [FLAGS_W-1:0] status_model;
  logic [7:0]         dmem_model [MEM_WORDS];

  result_t     pending_results [$];
  dir_row_t    dir_rows [$];
  int unsigned err_count      = 0;
  int unsigned result_count   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned hold_left      = 0;
  bit          hold_req       = 1'b0;
  bit          row_typed      = 1'b0;
  result_t     row_res        = '0;

  alu_execute_stage_8bit_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .dest_reg_i     (dest_reg_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .immediate_i    (immediate_i),
    .instr_pc_i     (instr_pc_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .reg_write_o    (reg_write_o),
    .write_reg_o    (write_reg_o),
    .write_value_o  (write_value_o),
    .flags_o        (flags_o),
    .branch_taken_o (branch_taken_o),
    .target_pc_o    (target_pc_o),
    .bad_opcode_o   (bad_opcode_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void model_sign_zero(input logic [7:0] v);
    status_model[FLAG_N] = v[7];
    status_model[FLAG_Z] = (v == 8'h00);
  endfunction

  function automatic result_t execute_instr(input instr_t ins);
    result_t    r;
    logic [8:0] sum;
    logic [7:0] ua, ub, v;
    logic [5:0] sh;
    logic       wr;
    r  = '0;
    wr = 1'b0;
    v  = '0;
    ua = ins.first_value;
    ub = ins.second_value;
    sh = ins.immediate[IMM_FIELD_W-1:0];
    case (ins.mode)
      OP_ADD: begin
        sum = {1'b0, ua} + {1'b0, ub};
        v   = sum[7:0];
        status_model[FLAG_C] = sum[8];
        status_model[FLAG_V] = (ua[7] == ub[7]) && (v[7] != ua[7]);
        model_sign_zero(v);
        status_model[FLAG_S] = status_model[FLAG_N] ^ status_model[FLAG_V];
        wr = 1'b1;
      end
      OP_SUB: begin
        // carry is left as it was
        v = ua - ub;
        status_model[FLAG_V] = (ua[7] != ub[7]) && (v[7] != ua[7]);
        model_sign_zero(v);
        status_model[FLAG_S] = status_model[FLAG_N] ^ status_model[FLAG_V];
        wr = 1'b1;
      end
      OP_MUL: begin
        v = ua * ub;
        model_sign_zero(v);
        wr = 1'b1;
      end
      OP_LDI: begin
        v  = ins.immediate;
        wr = 1'b1;
      end
      OP_BEQZ: begin
        if (ua == 8'h00) begin
          r.branch_taken = 1'b1;
          r.target_pc    = ins.instr_pc + 16'd1 + {{8{ins.immediate[7]}}, ins.immediate};
        end
      end
      OP_AND: begin
        v = ua & ub;
        model_sign_zero(v);
        wr = 1'b1;
      end
      OP_OR: begin
        v = ua | ub;
        model_sign_zero(v);
        wr = 1'b1;
      end
      OP_JR: begin
        r.branch_taken = 1'b1;
        r.target_pc    = {ua, ub};
      end
      OP_SAL: begin
        if (sh >= 6'd8) v = 8'h00;
        else v = ua << sh;
        model_sign_zero(v);
        wr = 1'b1;
      end
      OP_SAR: begin
        // amounts of 8 or more leave only the sign
        if (sh >= 6'd8) v = {8{ua[7]}};
        else v = $signed(ua) >>> sh;
        model_sign_zero(v);
        wr = 1'b1;
      end
      OP_LB: begin
        v  = dmem_model[sh];
        wr = 1'b1;
      end
      OP_SB: begin
        dmem_model[sh] = ua;
      end
      default: begin
        r.bad_opcode = 1'b1;
      end
    endcase
    if (wr) begin
      r.reg_write   = 1'b1;
      r.write_reg   = ins.dest_reg;
      r.write_value = v;
    end
    r.flags = status_model;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at result %0d: %s", result_count, what);
    err_count++;
  endtask

  // Accept requests into the model, check results, watch for a hang.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t predicted;
    instr_t  ins;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        ins = {mode_i, dest_reg_i, first_value_i, second_value_i, immediate_i, instr_pc_i};
        predicted = execute_instr(ins);
        pending_results.push_back(row_typed ? row_res : predicted);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        got = {reg_write_o, write_reg_o, write_value_o, flags_o, branch_taken_o,
               target_pc_o, bad_opcode_o};
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          if (got.reg_write !== want.reg_write)
            report_mismatch($sformatf("reg_write %0h, want %0h", got.reg_write, want.reg_write));
          if (got.write_reg !== want.write_reg)
            report_mismatch($sformatf("write_reg %0h, want %0h", got.write_reg, want.write_reg));
          if (got.write_value !== want.write_value)
            report_mismatch($sformatf("write_value %0h, want %0h", got.write_value,
                                      want.write_value));
          if (got.flags !== want.flags)
            report_mismatch($sformatf("flags %0b, want %0b", got.flags, want.flags));
          if (got.branch_taken !== want.branch_taken)
            report_mismatch($sformatf("branch_taken %0h, want %0h", got.branch_taken,
                                      want.branch_taken));
          if (got.target_pc !== want.target_pc)
            report_mismatch($sformatf("target_pc %0h, want %0h", got.target_pc, want.target_pc));
          if (got.bad_opcode !== want.bad_opcode)
            report_mismatch($sformatf("bad_opcode %0h, want %0h", got.bad_opcode,
                                      want.bad_opcode));
        end
        result_count++;
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, or a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_row(input instr_t ins, input bit typed, input result_t res);
    dir_row_t row;
    row.ins   = ins;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the accept.
  task automatic send_request(input instr_t ins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    mode_i         = ins.mode;
    dest_reg_i     = ins.dest_reg;
    first_value_i  = ins.first_value;
    second_value_i = ins.second_value;
    immediate_i    = ins.immediate;
    instr_pc_i     = ins.instr_pc;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random(input int count, input int hold_at, input int pause_at);
    for (int n = 0; n < count; n++) begin
      instr_t      ins;
      int unsigned pick;
      pick             = $urandom_range(99);
      ins.mode         = 4'($urandom_range(15));
      ins.dest_reg     = 6'($urandom);
      ins.first_value  = rand_byte();
      ins.second_value = rand_byte();
      ins.immediate    = rand_byte();
      ins.instr_pc     = 16'($urandom);
      if (pick < 20) begin
        // store/load traffic on a few shared addresses, upper immediate bits random
        ins.mode = (pick < 10) ? OP_SB : OP_LB;
        ins.immediate[5:0] = 6'($urandom_range(3) * 21);
      end else if ((ins.mode == OP_SAL || ins.mode == OP_SAR) && pick < 70) begin
        ins.immediate[5:0] = 6'($urandom_range(8));
      end else if (ins.mode == OP_BEQZ && pick < 70) begin
        ins.first_value = 8'h00;
      end
      if (n == hold_at) hold_req = 1'b1;
      if (n == pause_at) hold_until_drained();
      send_request(ins);
    end
  endtask

  initial begin
    for (int i = 0; i < MEM_WORDS; i++) dmem_model[i] = 8'h00;
    status_model = '0;

    // flags column: C V N S Z
    add_row({OP_LB,   6'd5,  8'h00, 8'h00, 8'h00, 16'h0000}, 1'b1,
            {1'b1, 6'd5,  8'h00, 5'b00000, 1'b0, 16'h0000, 1'b0});
    add_row({OP_ADD,  6'd1,  8'h7F, 8'h01, 8'h00, 16'h0000}, 1'b1,
            {1'b1, 6'd1,  8'h80, 5'b01100, 1'b0, 16'h0000, 1'b0});
    add_row({OP_ADD,  6'd2,  8'h80, 8'h80, 8'h00, 16'h0000}, 1'b1,
            {1'b1, 6'd2,  8'h00, 5'b11011, 1'b0, 16'h0000, 1'b0});
    add_row({OP_SUB,  6'd3,  8'h80, 8'h01, 8'h00, 16'h0000}, 1'b1,
            {1'b1, 6'd3,  8'h7F, 5'b11010, 1'b0, 16'h0000, 1'b0});
    add_row({OP_BAD_LO, 6'd4, 8'h05, 8'h06, 8'h00, 16'h1234}, 1'b1,
            {1'b0, 6'd0,  8'h00, 5'b11010, 1'b0, 16'h0000, 1'b1});
    add_row({OP_BAD_HI, 6'd63, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1,
            {1'b0, 6'd0,  8'h00, 5'b11010, 1'b0, 16'h0000, 1'b1});
    add_row({OP_MUL,  6'd7,  8'h10, 8'h10, 8'h00, 16'h0000}, 1'b1,
            {1'b1, 6'd7,  8'h00, 5'b11011, 1'b0, 16'h0000, 1'b0});
    add_row({OP_LDI,  6'd63, 8'h00, 8'h00, 8'h80, 16'h0000}, 1'b1,
            {1'b1, 6'd63, 8'h80, 5'b11011, 1'b0, 16'h0000, 1'b0});
    add_row({OP_BEQZ, 6'd9,  8'h00, 8'h00, 8'h7F, 16'hFFFF}, 1'b1,
            {1'b0, 6'd0,  8'h00, 5'b11011, 1'b1, 16'h007F, 1'b0});
    add_row({OP_BEQZ, 6'd9,  8'h00, 8'h00, 8'h80, 16'h0000}, 1'b1,
            {1'b0, 6'd0,  8'h00, 5'b11011, 1'b1, 16'hFF81, 1'b0});
    add_row({OP_BEQZ, 6'd9,  8'h01, 8'h00, 8'h05, 16'h0100}, 1'b1,
            {1'b0, 6'd0,  8'h00, 5'b11011, 1'b0, 16'h0000, 1'b0});
    add_row({OP_JR,   6'd0,  8'hFF, 8'hFF, 8'h00, 16'h0000}, 1'b1,
            {1'b0, 6'd0,  8'h00, 5'b11011, 1'b1, 16'hFFFF, 1'b0});
    add_row({OP_JR,   6'd0,  8'h00, 8'h00, 8'h00, 16'hABCD}, 1'b1,
            {1'b0, 6'd0,  8'h00, 5'b11011, 1'b1, 16'h0000, 1'b0});
    add_row({OP_AND,  6'd10, 8'hFF, 8'h55, 8'h00, 16'h0000}, 1'b0, '0);
    add_row({OP_OR,   6'd11, 8'h80, 8'h00, 8'h00, 16'h0000}, 1'b0, '0);
    add_row({OP_AND,  6'd10, 8'h00, 8'hFF, 8'h00, 16'h0000}, 1'b0, '0);
    add_row({OP_SAL,  6'd12, 8'h01, 8'h00, 8'h07, 16'h0000}, 1'b0, '0);
    add_row({OP_SAL,  6'd12, 8'h01, 8'h00, 8'h08, 16'h0000}, 1'b0, '0);
    add_row({OP_SAL,  6'd12, 8'hFF, 8'h00, 8'h7F, 16'h0000}, 1'b0, '0);
    add_row({OP_SAR,  6'd14, 8'h80, 8'h00, 8'h08, 16'h0000}, 1'b0, '0);
    add_row({OP_SAR,  6'd14, 8'h80, 8'h00, 8'h00, 16'h0000}, 1'b0, '0);
    add_row({OP_SAR,  6'd14, 8'h7F, 8'h00, 8'hFF, 16'h0000}, 1'b0, '0);
    add_row({OP_SAR,  6'd14, 8'h80, 8'h00, 8'hC3, 16'h0000}, 1'b0, '0);
    // store then load right behind it, at the top and bottom address
    add_row({OP_SB,   6'd0,  8'hA5, 8'h00, 8'hFF, 16'h0000}, 1'b0, '0);
    add_row({OP_LB,   6'd13, 8'h00, 8'h00, 8'h3F, 16'h0000}, 1'b0, '0);
    add_row({OP_SB,   6'd0,  8'h01, 8'h00, 8'h40, 16'h0000}, 1'b0, '0);
    add_row({OP_LB,   6'd13, 8'h00, 8'h00, 8'h00, 16'h0000}, 1'b0, '0);

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 25;
    recv_idle_pct = 76;
    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_res   = dir_rows[i].res;
      send_request(dir_rows[i].ins);
    end
    row_typed = 1'b0;
    send_random(600, -1, -1);
    hold_until_drained();

    send_idle_pct = 76;
    recv_idle_pct = 25;
    send_random(600, -1, -1);
    hold_until_drained();

    // back-to-back traffic; a long output hold-off fills the pipe
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(650, 50, 300);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== alu_execute_stage_8bit_top.f =====
rtl/aluex_pkg.sv
rtl/aluex_ram.sv
rtl/aluex_alu.sv
rtl/alu_execute_stage_8bit_top.sv
dv/tb.sv
